>>> rtl/sorted_wakeup_timer_queue_assert.svh
// Assertion macros for the sorted wakeup timer queue checker.
// Needs signals clk and rst_n in the scope of each use.
`ifndef SORTED_WAKEUP_TIMER_QUEUE_ASSERT_SVH
`define SORTED_WAKEUP_TIMER_QUEUE_ASSERT_SVH

// Clocked assertion, held off during reset.
`define SWTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every clock edge after reset.
`define SWTQ_ASSERT_IMP(lbl, ante, cons, msg) \
  `SWTQ_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> rtl/swtq_pkg.sv
// Shared constants, types and status codes for the sorted wakeup timer queue.
// No dependencies.
package swtq_pkg;

  localparam int DEPTH       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int TIME_W      = 63;
  localparam int ID_W        = 8;
  localparam int STATUS_W    = 3;
  localparam int CNT_W       = $clog2(MAX_RESULTS);
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 16;

  typedef logic [TIME_W-1:0]   tick_t;
  typedef logic [ID_W-1:0]     id_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STAT_INSERTED = 3'd0;
  localparam status_t STAT_PAST     = 3'd1;
  localparam status_t STAT_IDLE     = 3'd2;
  localparam status_t STAT_FULL     = 3'd3;
  localparam status_t STAT_WOKEN    = 3'd4;
  localparam status_t STAT_NONE_DUE = 3'd5;

  localparam logic REQ_SLEEP = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_RESULTS - 1);

  // Broadcast command to every cell of the chain.
  typedef struct packed {
    logic  ins;
    logic  pop;
    tick_t key;
    id_t   id;
  } chain_cmd_t;

  // Chain status seen by the controller.
  typedef struct packed {
    logic full;
    logic head_due;
    logic next_due;
    id_t  head_id;
  } chain_stat_t;

endpackage

>>> rtl/sorted_wakeup_timer_queue.sv
// Sorted wakeup timer queue: a shifting chain of DEPTH sleeper cells.
// Sleep request: accepted in idle, result beat registered from the sleep state once the output is free;
//   no new request is taken until then. Tick: the time is captured, then one woken beat per cycle
//   (one pop of the chain each) while the output is not stalled, or one none-due beat if none is due.
// Reset (rst_n low, synchronous) empties the chain, clears the idle id and the output.
// Depends on swtq_pkg and swtq_chain.
module sorted_wakeup_timer_queue import swtq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [ID_W-1:0]        cfg_wr_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // thread_id[7:0], wake_time[70:8], now_ticks[133:71]
  input  logic                   in_tuser,   // req_type
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // status[2:0], woken_id[10:3]
  output logic                   out_tlast
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SLEEP = 2'd1;
  localparam logic [1:0] S_TICK  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  tick_t            key_r, key_nxt;
  id_t              id_r, id_nxt;
  logic             past_r, past_nxt;
  logic             is_idle_r, is_idle_nxt;
  id_t              idle_id_r;

  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  id_t     out_id_r, out_id_nxt;
  logic    out_last_r, out_last_nxt;

  chain_cmd_t  cmd;
  chain_stat_t stat;

  id_t   in_thread_id;
  tick_t in_wake, in_now;
  logic  in_fire, out_free;

  assign in_thread_id = in_tdata[ID_W-1:0];
  assign in_wake      = in_tdata[ID_W+TIME_W-1:ID_W];
  assign in_now       = in_tdata[ID_W+2*TIME_W-1:ID_W+TIME_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    key_nxt        = key_r;
    id_nxt         = id_r;
    past_nxt       = past_r;
    is_idle_nxt    = is_idle_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_last_nxt   = out_last_r;
    cmd.ins        = 1'b0;
    cmd.pop        = 1'b0;
    cmd.key        = key_r;
    cmd.id         = id_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          key_nxt     = (in_tuser == REQ_TICK) ? in_now : in_wake;
          id_nxt      = in_thread_id;
          past_nxt    = (in_wake < in_now);
          is_idle_nxt = (in_thread_id == idle_id_r);
          cnt_nxt     = '0;
          state_nxt   = (in_tuser == REQ_TICK) ? S_TICK : S_SLEEP;
        end
      end
      S_SLEEP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = '0;
          out_last_nxt  = 1'b1;
          if (past_r) begin
            out_status_nxt = STAT_PAST;
          end else if (is_idle_r) begin
            out_status_nxt = STAT_IDLE;
          end else if (stat.full) begin
            out_status_nxt = STAT_FULL;
          end else begin
            out_status_nxt = STAT_INSERTED;
            cmd.ins        = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_TICK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (stat.head_due) begin
            // Pop the head; close the run when the next one is not due or the cap is hit.
            out_status_nxt = STAT_WOKEN;
            out_id_nxt     = stat.head_id;
            out_last_nxt   = ~stat.next_due | (cnt_r == CNT_LAST);
            cmd.pop        = 1'b1;
            cnt_nxt        = cnt_r + 1'b1;
            if (out_last_nxt) begin
              state_nxt = S_IDLE;
            end
          end else begin
            out_status_nxt = STAT_NONE_DUE;
            out_id_nxt     = '0;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  swtq_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      idle_id_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        idle_id_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    key_r        <= key_nxt;
    id_r         <= id_nxt;
    past_r       <= past_nxt;
    is_idle_r    <= is_idle_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-STATUS_W-ID_W){1'b0}}, out_id_r, out_status_r};
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/swtq_cell.sv
// One slot of the sorted chain: holds a sleeper and shifts with its neighbors.
// Depends on swtq_pkg.
module swtq_cell import swtq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  chain_cmd_t cmd,
  input  logic       is_head,
  input  logic       prev_before,
  input  logic       prev_valid,
  input  tick_t      prev_time,
  input  id_t        prev_id,
  input  logic       next_valid,
  input  tick_t      next_time,
  input  id_t        next_id,
  output logic       cell_valid,
  output tick_t      cell_time,
  output id_t        cell_id,
  output logic       ins_here,
  output logic       due
);

  logic  valid_r, valid_nxt;
  tick_t time_r, time_nxt;
  id_t   id_r, id_nxt;
  logic  key_le_time;
  logic  time_le_key;

  assign key_le_time = (cmd.key <= time_r);
  assign time_le_key = (time_r <= cmd.key);

  // New entry lands at or before this slot; the head takes ties in front.
  assign ins_here = prev_before | ~valid_r | (is_head ? key_le_time : ~time_le_key);
  assign due      = valid_r & time_le_key;

  always_comb begin
    valid_nxt = valid_r;
    time_nxt  = time_r;
    id_nxt    = id_r;
    if (cmd.pop) begin
      valid_nxt = next_valid;
      time_nxt  = next_time;
      id_nxt    = next_id;
    end else if (cmd.ins) begin
      if (prev_before) begin
        valid_nxt = prev_valid;
        time_nxt  = prev_time;
        id_nxt    = prev_id;
      end else if (ins_here) begin
        valid_nxt = 1'b1;
        time_nxt  = cmd.key;
        id_nxt    = cmd.id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    id_r   <= id_nxt;
  end

  assign cell_valid = valid_r;
  assign cell_time  = time_r;
  assign cell_id    = id_r;

endmodule

>>> rtl/swtq_chain.sv
// Row of DEPTH cells kept sorted by wake time, head at slot zero.
// Depends on swtq_pkg and swtq_cell.
module swtq_chain import swtq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  chain_cmd_t  cmd,
  output chain_stat_t stat
);

  logic  valid [DEPTH];
  tick_t times [DEPTH];
  id_t   ids   [DEPTH];
  logic  bef   [DEPTH];
  logic  dues  [DEPTH];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic  p_before, p_valid, n_valid;
      tick_t p_time, n_time;
      id_t   p_id, n_id;

      if (i == 0) begin : g_head
        assign p_before = 1'b0;
        assign p_valid  = 1'b0;
        assign p_time   = '0;
        assign p_id     = '0;
      end else begin : g_body
        assign p_before = bef[i-1];
        assign p_valid  = valid[i-1];
        assign p_time   = times[i-1];
        assign p_id     = ids[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign n_valid = 1'b0;
        assign n_time  = '0;
        assign n_id    = '0;
      end else begin : g_mid
        assign n_valid = valid[i+1];
        assign n_time  = times[i+1];
        assign n_id    = ids[i+1];
      end

      swtq_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .is_head     (i == 0),
        .prev_before (p_before),
        .prev_valid  (p_valid),
        .prev_time   (p_time),
        .prev_id     (p_id),
        .next_valid  (n_valid),
        .next_time   (n_time),
        .next_id     (n_id),
        .cell_valid  (valid[i]),
        .cell_time   (times[i]),
        .cell_id     (ids[i]),
        .ins_here    (bef[i]),
        .due         (dues[i])
      );
    end
  endgenerate

  assign stat.full     = valid[DEPTH-1];
  assign stat.head_due = dues[0];
  assign stat.next_due = dues[1];
  assign stat.head_id  = ids[0];

endmodule

>>> rtl/swtq_checker.sv
// Port-level checker for the sorted wakeup timer queue, bound to the top level.
// Depends on swtq_pkg and sorted_wakeup_timer_queue_assert.svh.
`include "sorted_wakeup_timer_queue_assert.svh"

module swtq_checker import swtq_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  status_t st;
  id_t     wid;

  assign st  = out_tdata[STATUS_W-1:0];
  assign wid = out_tdata[STATUS_W+ID_W-1:STATUS_W];

  // Hold a stalled beat.
  `SWTQ_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result beat changed")
  `SWTQ_ASSERT_IMP(a_id_zero, out_tvalid && st != STAT_WOKEN, wid == '0, "nonzero id on a non-woken beat")
  `SWTQ_ASSERT_IMP(a_single_last, out_tvalid && st != STAT_WOKEN, out_tlast, "single-beat result without last")
  // A run of woken beats blocks new requests until its last beat.
  `SWTQ_ASSERT_IMP(a_run_blocks, out_tvalid && !out_tlast, !in_tready, "request taken in the middle of a run")

endmodule

bind sorted_wakeup_timer_queue swtq_checker u_swtq_checker (.*);
